// File: hw/rtl/ccls_pkg.sv
// ----------------------------------------------------------------------------
// ccls_pkg
// Types, constants and helpers shared by the comment line statistics unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ccls_pkg;

   localparam int COUNT_BITS = 32;
   localparam int OUT_BITS   = 32;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [OUT_BITS-1:0]   out_count_type;

   typedef enum logic [2:0] {
      MODE_NORMAL  = 3'd0,
      MODE_SLASH   = 3'd1,
      MODE_BLOCK   = 3'd2,
      MODE_LINE    = 3'd3,
      MODE_LINE_BS = 3'd4
   } scan_mode_type;

   localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;
   localparam logic [7:0] CHAR_SLASH     = 8'h2f;
   localparam logic [7:0] CHAR_STAR      = 8'h2a;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;

   typedef struct packed {
      scan_mode_type scan_mode;
      logic          prev_was_star;
      count_type     current_line_len;
      count_type     byte_count;
      count_type     comment_count;
      count_type     newline_count;
      count_type     max_line_len;
   } scan_state_type;

   localparam scan_state_type SCAN_STATE_RESET = '{
      scan_mode:        MODE_NORMAL,
      prev_was_star:    1'b0,
      current_line_len: '0,
      byte_count:       '0,
      comment_count:    '0,
      newline_count:    COUNT_BITS'(1),
      max_line_len:     '0
   };

   // low output bits of a counter, zero-extended when the counter is narrower
   function automatic out_count_type cnt_to_out(input count_type value);
      logic [63:0] wide;
      wide = 64'(value);
      return wide[OUT_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ccls_step.sv
// ----------------------------------------------------------------------------
// ccls_step
// Next scanner state for one text byte: mode, counters and line lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module ccls_step
   import ccls_pkg::*;
(
   input  wire scan_state_type cur_state,
   input  wire logic [7:0]     text_byte,
   input  wire logic           file_start,
   output scan_state_type      next_state,
   output logic                in_comment
);

   scan_state_type base;
   count_type      line_len;
   count_type      nl_count;
   count_type      nl_max;
   logic           is_nl;

   always_comb begin
      base     = file_start ? SCAN_STATE_RESET : cur_state;
      is_nl    = (text_byte == CHAR_NEWLINE);
      line_len = base.current_line_len + COUNT_BITS'(1);
      // line end: the length here still counts the newline itself
      nl_count = base.newline_count + COUNT_BITS'(1);
      nl_max   = (line_len > base.max_line_len) ? (line_len - COUNT_BITS'(1))
                                                : base.max_line_len;
   end

   // next state
   always_comb begin
      next_state                  = base;
      next_state.byte_count       = base.byte_count + COUNT_BITS'(1);
      next_state.current_line_len = line_len;
      if (is_nl) begin
         next_state.newline_count    = nl_count;
         next_state.max_line_len     = nl_max;
         next_state.current_line_len = '0;
      end
      unique case (base.scan_mode)
         MODE_SLASH: begin
            if (is_nl) begin
               next_state.scan_mode = MODE_NORMAL;
            end else if (text_byte == CHAR_STAR) begin
               next_state.comment_count = base.comment_count + COUNT_BITS'(2);
               next_state.prev_was_star = 1'b0;
               next_state.scan_mode     = MODE_BLOCK;
            end else if (text_byte == CHAR_SLASH) begin
               next_state.comment_count = base.comment_count + COUNT_BITS'(2);
               next_state.scan_mode     = MODE_LINE;
            end else begin
               next_state.scan_mode = MODE_NORMAL;
            end
         end
         MODE_BLOCK: begin
            next_state.comment_count = base.comment_count + COUNT_BITS'(1);
            if (is_nl) begin
               next_state.prev_was_star = 1'b0;
            end else if (base.prev_was_star && text_byte == CHAR_SLASH) begin
               next_state.prev_was_star = 1'b0;
               next_state.scan_mode     = MODE_NORMAL;
            end else begin
               next_state.prev_was_star = (text_byte == CHAR_STAR);
            end
         end
         MODE_LINE: begin
            next_state.comment_count = base.comment_count + COUNT_BITS'(1);
            if (is_nl) begin
               next_state.scan_mode = MODE_NORMAL;
            end else if (text_byte == CHAR_BACKSLASH) begin
               next_state.scan_mode = MODE_LINE_BS;
            end
         end
         MODE_LINE_BS: begin
            next_state.comment_count = base.comment_count + COUNT_BITS'(1);
            // blanks keep the continuation check open, anything else drops it
            if (is_nl || (text_byte != CHAR_SPACE && text_byte != CHAR_TAB)) begin
               next_state.scan_mode = MODE_LINE;
            end
         end
         default: begin
            if (!is_nl && text_byte == CHAR_SLASH) begin
               next_state.scan_mode = MODE_SLASH;
            end else begin
               next_state.scan_mode = MODE_NORMAL;
            end
         end
      endcase
   end

   // outputs
   always_comb begin
      unique case (next_state.scan_mode) inside
         MODE_BLOCK, MODE_LINE, MODE_LINE_BS: in_comment = 1'b1;
         default:                             in_comment = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/c_comment_line_statistics_unit.sv
// ----------------------------------------------------------------------------
// c_comment_line_statistics_unit
// Scans C source text a byte per beat and reports running byte, comment-byte,
// line and longest-line counts after every byte.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_stall   text_byte, file_start
//   rsp       out         rsp_valid / rsp_stall   four counts, in_comment
//
// one byte per cycle sustained while the result is not stalled; a byte's result
// is registered: the beat lands in the input register, and once the result slot
// is free the step logic passes it into the result register. the longest path is
// a 32-bit increment feeding a compare. reset is synchronous and puts the scanner
// in normal text with zero counts and a line count of one. a stalled result holds
// while one more byte waits in the input register; further beats are stalled
// until the result moves.
//
`default_nettype none

module c_comment_line_statistics_unit
   import ccls_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [7:0]    req_text_byte,
   input  wire logic          req_file_start,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output out_count_type      rsp_total_bytes,
   output out_count_type      rsp_comment_bytes,
   output out_count_type      rsp_line_total,
   output out_count_type      rsp_longest_line,
   output logic               rsp_in_comment
);

   logic           s1_valid_ff, s1_valid_in;
   logic [7:0]     s1_byte_ff;
   logic           s1_start_ff;
   scan_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   out_count_type  total_ff, comment_ff, lines_ff, longest_ff;
   logic           in_comment_ff;
   logic           step_in_comment;
   logic           advance;
   logic           req_accept;

   ccls_step u_step (
      .cur_state  (state_ff),
      .text_byte  (s1_byte_ff),
      .file_start (s1_start_ff),
      .next_state (state_in),
      .in_comment (step_in_comment)
   );

   // result slot free or being taken this cycle
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = req_accept || (s1_valid_ff && !advance);
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= SCAN_STATE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance && s1_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff  <= req_text_byte;
         s1_start_ff <= req_file_start;
      end
      if (advance && s1_valid_ff) begin
         total_ff      <= cnt_to_out(state_in.byte_count);
         comment_ff    <= cnt_to_out(state_in.comment_count);
         lines_ff      <= cnt_to_out(state_in.newline_count);
         longest_ff    <= cnt_to_out(state_in.max_line_len);
         in_comment_ff <= step_in_comment;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_total_bytes   = total_ff;
   assign rsp_comment_bytes = comment_ff;
   assign rsp_line_total    = lines_ff;
   assign rsp_longest_line  = longest_ff;
   assign rsp_in_comment    = in_comment_ff;

endmodule

`default_nettype wire

// File: tb/sv/tb_c_comment_line_statistics_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_c_comment_line_statistics_unit
// Feeds C-like text through the comment line statistics unit a byte per beat.
// Starts with a short directed table covering comment openings and closings,
// continued line comments and file restarts. Random text made of words,
// comments, continuations and raw noise follows. Each result beat is checked
// field by field against typed rows' own stats or else a bench scanner model,
// under bursty sender traffic and a shifting receiver stall pattern.
// ----------------------------------------------------------------------------

module tb_c_comment_line_statistics_unit
   import ccls_pkg::*;
();

   localparam int DIRECTED_COUNT = 25;
   localparam int RANDOM_BYTES   = 800;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int PRINT_LIMIT    = 100;

   typedef struct packed {
      out_count_type total_bytes;
      out_count_type comment_bytes;
      out_count_type line_total;
      out_count_type longest_line;
      logic          in_comment;
   } line_stats_type;

   // typed rows carry their own expected stats, the rest use the scanner model
   typedef struct packed {
      logic [7:0]     ch;
      logic           fs;
      logic           typed;
      line_stats_type want;
   } text_item_type;

   localparam line_stats_type FIRST_BYTE_STATS = '{32'd1, 32'd0, 32'd1, 32'd0, 1'b0};
   localparam line_stats_type NO_STATS         = '0;

   localparam text_item_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{8'h61,          1'b1, 1'b1, FIRST_BYTE_STATS},
      '{CHAR_NEWLINE,   1'b0, 1'b1, '{32'd2, 32'd0, 32'd2, 32'd1, 1'b0}},
      '{CHAR_SLASH,     1'b0, 1'b0, NO_STATS},
      '{CHAR_STAR,      1'b0, 1'b0, NO_STATS},
      // opening star must not close the comment
      '{CHAR_SLASH,     1'b0, 1'b0, NO_STATS},
      '{CHAR_STAR,      1'b0, 1'b0, NO_STATS},
      '{CHAR_SLASH,     1'b0, 1'b0, NO_STATS},
      // slash then an ordinary byte
      '{CHAR_SLASH,     1'b0, 1'b0, NO_STATS},
      '{8'h78,          1'b0, 1'b0, NO_STATS},
      '{CHAR_SLASH,     1'b0, 1'b0, NO_STATS},
      '{CHAR_SLASH,     1'b0, 1'b0, NO_STATS},
      // continuation with blanks between backslash and newline
      '{CHAR_BACKSLASH, 1'b0, 1'b0, NO_STATS},
      '{CHAR_SPACE,     1'b0, 1'b0, NO_STATS},
      '{CHAR_TAB,       1'b0, 1'b0, NO_STATS},
      '{CHAR_NEWLINE,   1'b0, 1'b0, NO_STATS},
      '{CHAR_BACKSLASH, 1'b0, 1'b0, NO_STATS},
      '{8'h71,          1'b0, 1'b0, NO_STATS},
      '{CHAR_NEWLINE,   1'b0, 1'b0, NO_STATS},
      '{CHAR_SLASH,     1'b0, 1'b0, NO_STATS},
      '{CHAR_NEWLINE,   1'b0, 1'b0, NO_STATS},
      '{8'hff,          1'b1, 1'b1, FIRST_BYTE_STATS},
      '{8'h00,          1'b0, 1'b0, NO_STATS},
      '{CHAR_SLASH,     1'b1, 1'b1, FIRST_BYTE_STATS},
      // restart drops the pending slash
      '{CHAR_STAR,      1'b1, 1'b1, FIRST_BYTE_STATS},
      '{CHAR_NEWLINE,   1'b0, 1'b0, NO_STATS}
   };

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [7:0]    req_text_byte = '0;
   logic          req_file_start = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   out_count_type rsp_total_bytes;
   out_count_type rsp_comment_bytes;
   out_count_type rsp_line_total;
   out_count_type rsp_longest_line;
   logic          rsp_in_comment;

   text_item_type  text_q[$];
   line_stats_type pending_stats[$];
   int             mismatch_count = 0;
   int             rsp_count = 0;
   int             cycle_count = 0;
   int             stall_style = 0;
   int             stall_phase_left = 0;

   // scanner model state
   scan_mode_type sc_mode;
   logic          sc_star;
   count_type     sc_line_len;
   count_type     sc_bytes;
   count_type     sc_comment;
   count_type     sc_lines;
   count_type     sc_longest;

   c_comment_line_statistics_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_text_byte     (req_text_byte),
      .req_file_start    (req_file_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_total_bytes   (rsp_total_bytes),
      .rsp_comment_bytes (rsp_comment_bytes),
      .rsp_line_total    (rsp_line_total),
      .rsp_longest_line  (rsp_longest_line),
      .rsp_in_comment    (rsp_in_comment)
   );

   always #1 clock = ~clock;

   task automatic clear_scan();
      sc_mode     = MODE_NORMAL;
      sc_star     = 1'b0;
      sc_line_len = '0;
      sc_bytes    = '0;
      sc_comment  = '0;
      sc_lines    = count_type'(1);
      sc_longest  = '0;
   endtask

   // line length already includes the newline here
   task automatic close_line();
      sc_lines = sc_lines + 1'b1;
      if (sc_line_len > sc_longest) begin
         sc_longest = sc_line_len - 1'b1;
      end
      sc_line_len = '0;
   endtask

   task automatic scan_byte(input logic [7:0] ch, input logic fs,
                            output line_stats_type res);
      logic nl;
      nl = (ch == CHAR_NEWLINE);
      if (fs) begin
         clear_scan();
      end
      sc_bytes    = sc_bytes + 1'b1;
      sc_line_len = sc_line_len + 1'b1;
      case (sc_mode)
         MODE_SLASH: begin
            if (nl) begin
               close_line();
               sc_mode = MODE_NORMAL;
            end else if (ch == CHAR_STAR) begin
               sc_comment = sc_comment + count_type'(2);
               sc_star    = 1'b0;
               sc_mode    = MODE_BLOCK;
            end else if (ch == CHAR_SLASH) begin
               sc_comment = sc_comment + count_type'(2);
               sc_mode    = MODE_LINE;
            end else begin
               sc_mode = MODE_NORMAL;
            end
         end
         MODE_BLOCK: begin
            sc_comment = sc_comment + 1'b1;
            if (nl) begin
               close_line();
               sc_star = 1'b0;
            end else if (sc_star && ch == CHAR_SLASH) begin
               sc_star = 1'b0;
               sc_mode = MODE_NORMAL;
            end else begin
               sc_star = (ch == CHAR_STAR);
            end
         end
         MODE_LINE: begin
            sc_comment = sc_comment + 1'b1;
            if (nl) begin
               close_line();
               sc_mode = MODE_NORMAL;
            end else if (ch == CHAR_BACKSLASH) begin
               sc_mode = MODE_LINE_BS;
            end
         end
         MODE_LINE_BS: begin
            sc_comment = sc_comment + 1'b1;
            if (nl) begin
               close_line();
               sc_mode = MODE_LINE;
            end else if (ch != CHAR_SPACE && ch != CHAR_TAB) begin
               sc_mode = MODE_LINE;
            end
         end
         default: begin
            if (nl) begin
               close_line();
               sc_mode = MODE_NORMAL;
            end else if (ch == CHAR_SLASH) begin
               sc_mode = MODE_SLASH;
            end else begin
               sc_mode = MODE_NORMAL;
            end
         end
      endcase
      res.total_bytes   = out_count_type'(sc_bytes);
      res.comment_bytes = out_count_type'(sc_comment);
      res.line_total    = out_count_type'(sc_lines);
      res.longest_line  = out_count_type'(sc_longest);
      res.in_comment    = (sc_mode == MODE_BLOCK || sc_mode == MODE_LINE ||
                           sc_mode == MODE_LINE_BS);
   endtask

   task automatic add_byte(input logic [7:0] ch, input logic fs);
      text_item_type it;
      it    = '0;
      it.ch = ch;
      it.fs = fs;
      text_q.push_back(it);
   endtask

   function automatic logic [7:0] printable();
      return 8'($urandom_range(32, 126));
   endfunction

   function automatic logic [7:0] blank();
      return ($urandom_range(0, 1) != 0) ? CHAR_SPACE : CHAR_TAB;
   endfunction

   // one piece of source text, now and then starting a new file
   task automatic add_fragment();
      int   n;
      int   k;
      logic fs;
      fs = ($urandom_range(0, 59) == 0);
      case ($urandom_range(0, 9))
         0, 1: begin
            n = $urandom_range(1, 12);
            for (k = 0; k < n; k++) begin
               add_byte(printable(), fs);
               fs = 1'b0;
            end
            if ($urandom_range(0, 1) != 0) begin
               add_byte(CHAR_NEWLINE, 1'b0);
            end
         end
         2: add_byte(CHAR_NEWLINE, fs);
         3, 4: begin
            add_byte(CHAR_SLASH, fs);
            add_byte(CHAR_STAR, 1'b0);
            n = $urandom_range(0, 15);
            for (k = 0; k < n; k++) begin
               case ($urandom_range(0, 5))
                  0: add_byte(CHAR_STAR, 1'b0);
                  1: add_byte(CHAR_SLASH, 1'b0);
                  2: add_byte(CHAR_NEWLINE, 1'b0);
                  default: add_byte(printable(), 1'b0);
               endcase
            end
            // mostly closed, sometimes left open
            if ($urandom_range(0, 9) != 0) begin
               add_byte(CHAR_STAR, 1'b0);
               add_byte(CHAR_SLASH, 1'b0);
            end
         end
         5, 6: begin
            add_byte(CHAR_SLASH, fs);
            add_byte(CHAR_SLASH, 1'b0);
            n = $urandom_range(0, 10);
            for (k = 0; k < n; k++) begin
               case ($urandom_range(0, 4))
                  0: add_byte(CHAR_BACKSLASH, 1'b0);
                  1: add_byte(blank(), 1'b0);
                  default: add_byte(printable(), 1'b0);
               endcase
            end
            if ($urandom_range(0, 1) != 0) begin
               add_byte(CHAR_BACKSLASH, 1'b0);
               n = $urandom_range(0, 3);
               for (k = 0; k < n; k++) begin
                  add_byte(blank(), 1'b0);
               end
               if ($urandom_range(0, 3) == 0) begin
                  add_byte(printable(), 1'b0);
               end
               add_byte(CHAR_NEWLINE, 1'b0);
               n = $urandom_range(0, 6);
               for (k = 0; k < n; k++) begin
                  add_byte(printable(), 1'b0);
               end
            end
            add_byte(CHAR_NEWLINE, 1'b0);
         end
         7: begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) begin
               add_byte(8'($urandom_range(0, 255)), fs);
               fs = 1'b0;
            end
         end
         8: begin
            add_byte(CHAR_SLASH, fs);
            case ($urandom_range(0, 3))
               0: add_byte(CHAR_NEWLINE, 1'b0);
               1: add_byte(CHAR_SLASH, 1'b0);
               2: add_byte(CHAR_STAR, 1'b0);
               default: add_byte(printable(), 1'b0);
            endcase
         end
         default: begin
            n = $urandom_range(20, 200);
            for (k = 0; k < n; k++) begin
               add_byte(printable(), fs);
               fs = 1'b0;
            end
            add_byte(CHAR_NEWLINE, 1'b0);
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("result %0d %s: got %0d, want %0d", rsp_count, what, got, want);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver stall style is redrawn each time its phase runs out
   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         stall_style      <= $urandom_range(0, 3);
         stall_phase_left <= $urandom_range(20, 150);
      end else begin
         stall_phase_left <= stall_phase_left - 1;
      end
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= cycle_count[2];
         default: rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   always @(posedge clock) begin : check_results
      line_stats_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_stats.size() == 0) begin
            report_mismatch("beat with nothing pending, total_bytes", rsp_total_bytes, '0);
         end else begin
            want = pending_stats.pop_front();
            if (rsp_total_bytes !== want.total_bytes) begin
               report_mismatch("total_bytes", rsp_total_bytes, want.total_bytes);
            end
            if (rsp_comment_bytes !== want.comment_bytes) begin
               report_mismatch("comment_bytes", rsp_comment_bytes, want.comment_bytes);
            end
            if (rsp_line_total !== want.line_total) begin
               report_mismatch("line_total", rsp_line_total, want.line_total);
            end
            if (rsp_longest_line !== want.longest_line) begin
               report_mismatch("longest_line", rsp_longest_line, want.longest_line);
            end
            if (rsp_in_comment !== want.in_comment) begin
               report_mismatch("in_comment", 32'(rsp_in_comment), 32'(want.in_comment));
            end
         end
         rsp_count++;
      end
   end

   initial begin : drive_text
      int             idx;
      int             burst_left;
      int             gap_left;
      int             drain_at;
      bit             drained;
      bit             next_valid;
      line_stats_type predicted;

      clear_scan();
      foreach (DIRECTED_ROWS[i]) begin
         text_q.push_back(DIRECTED_ROWS[i]);
      end
      while (text_q.size() < DIRECTED_COUNT + RANDOM_BYTES) begin
         add_fragment();
      end

      idx        = 0;
      burst_left = 0;
      gap_left   = 0;
      drained    = 1'b0;
      drain_at   = DIRECTED_COUNT + $urandom_range(100, 500);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (idx < text_q.size()) begin
         @(posedge clock);
         if (req_valid && !req_stall) begin
            scan_byte(text_q[idx].ch, text_q[idx].fs, predicted);
            pending_stats.push_back(text_q[idx].typed ? text_q[idx].want : predicted);
            idx++;
            if (burst_left > 0) begin
               burst_left--;
            end
         end
         // a stalled beat keeps its payload
         if (!(req_valid && req_stall)) begin
            if (idx >= text_q.size()) begin
               next_valid = 1'b0;
            end else if (idx == drain_at && !drained) begin
               next_valid = 1'b0;
               drained    = (pending_stats.size() == 0);
            end else if (burst_left == 0) begin
               if (gap_left == 0) begin
                  burst_left = $urandom_range(1, 32);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                  next_valid = 1'b1;
               end else begin
                  gap_left--;
                  next_valid = 1'b0;
               end
            end else begin
               next_valid = 1'b1;
            end
            req_valid <= next_valid;
            if (next_valid) begin
               req_text_byte  <= text_q[idx].ch;
               req_file_start <= text_q[idx].fs;
            end
         end
      end

      while (pending_stats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
